// ===== rtl/prlc_pkg.sv =====
package prlc_pkg;

    localparam int unsigned CMD_W       = 2;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned SECONDS_W   = 14;
    localparam int unsigned MANUAL_W    = 8;
    localparam int unsigned AUTO_W      = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned IN_DATA_W   = 8;
    localparam int unsigned OUT_DATA_W  = 24;

    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned MANUAL_MAX   = 180;
    localparam int unsigned AUTO_MIN     = 1;
    localparam int unsigned AUTO_MAX     = 60;
    localparam int unsigned AUTO_RESET   = 5;
    localparam int unsigned SECONDS_MAX  = MANUAL_MAX * SECS_PER_MIN;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE   = 2'd0,
        CMD_TOGGLE   = 2'd1,
        CMD_SET_MODE = 2'd2
    } cmd_t;

    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALARM  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_KEEP   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_TIMER = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_TIMER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DAY_NIGHT    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]    new_mode;
        logic                 second_tick;
        logic                 is_day;
        logic                 pir_level;
        logic [CMD_W-1:0]     cmd;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic                 relay;
        logic [SECONDS_W-1:0] seconds_left;
        logic                 wait_pir_low;
        logic                 pir_qualified;
    } state_t;

    typedef struct packed {
        logic [MANUAL_W-1:0]  manual_timer_minutes;
        logic [AUTO_W-1:0]    auto_timer_minutes;
        logic                 day_night_enabled;
    } cfg_t;

    function automatic logic [SECONDS_W-1:0] minutes_to_seconds(
        input logic [MANUAL_W-1:0] minutes
    );
        return SECONDS_W'(minutes) * SECONDS_W'(SECS_PER_MIN);
    endfunction

endpackage

// ===== rtl/pir_relay_light_controller_unit.sv =====
// pir relay light controller
// input stream s_*: one transaction per command (update, toggle, set mode);
// each accepted transaction yields exactly one result transaction on m_*
// carrying relay, qualified motion, remaining seconds, mode and lockout
// after that command.
// the input transaction is captured in the input register; the next-state
// logic computes the result from it and loads the result register, which
// drives the result transaction on m_*.
// throughput: one transaction per cycle while the result is not stalled; the
// controller state is updated in the same cycle the item moves to the result
// register, so back-to-back items each see the state left by the one before.
// cfg_wr_en/cfg_index/cfg_data write a setting; manual saturates at 180, auto
// clamps cfg_data[5:0] to 1..60, unknown indexes are ignored. write only while idle.
// reset: mode manual, relay off, no timer, no lockout, manual timer 0,
// auto timer 5 minutes, day/night blocking off; both stages empty.
// stall: while m_tready is low the result holds, one more item is held in
// the input register and s_tready then drops.
module pir_relay_light_controller_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // cmd[1:0], pir_level[2], is_day[3], second_tick[4], new_mode[6:5], zero[7]
    input  logic [prlc_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // relay[0], pir_detected[1], remaining_seconds[15:2], mode_now[17:16],
    // lockout[18], zero[23:19]
    output logic [prlc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [prlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [prlc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned ResultW = $bits(prlc_pkg::state_t);

    logic                  in_valid_reg;
    logic                  in_valid_next;
    prlc_pkg::item_t       in_item_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [prlc_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [prlc_pkg::OUT_DATA_W-1:0] out_data_next;
    prlc_pkg::state_t      state_reg;
    prlc_pkg::state_t      state_next;
    prlc_pkg::cfg_t        cfg_reg;
    prlc_pkg::cfg_t        cfg_next;
    logic                  advance;
    logic                  in_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    prlc_next_state u_next_state (
        .item       (in_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        out_data_next = {
            (prlc_pkg::OUT_DATA_W - ResultW)'(0),
            state_next.wait_pir_low,
            state_next.mode,
            state_next.seconds_left,
            state_next.pir_qualified,
            state_next.relay
        };
    end

    // settings saturate into their legal ranges; the auto timer uses only cfg_data[5:0]
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                prlc_pkg::REG_MANUAL_TIMER:
                begin
                    cfg_next.manual_timer_minutes =
                        (cfg_data > prlc_pkg::CFG_DATA_W'(prlc_pkg::MANUAL_MAX)) ?
                        prlc_pkg::MANUAL_W'(prlc_pkg::MANUAL_MAX) :
                        prlc_pkg::MANUAL_W'(cfg_data);
                end
                prlc_pkg::REG_AUTO_TIMER:
                begin
                    if (cfg_data[prlc_pkg::AUTO_W-1:0] <
                        prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MIN))
                    begin
                        cfg_next.auto_timer_minutes = prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MIN);
                    end
                    else if (cfg_data[prlc_pkg::AUTO_W-1:0] >
                             prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MAX))
                    begin
                        cfg_next.auto_timer_minutes = prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MAX);
                    end
                    else
                    begin
                        cfg_next.auto_timer_minutes = cfg_data[prlc_pkg::AUTO_W-1:0];
                    end
                end
                prlc_pkg::REG_DAY_NIGHT:
                begin
                    cfg_next.day_night_enabled = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            state_reg.mode               <= prlc_pkg::MODE_MANUAL;
            state_reg.relay              <= 1'b0;
            state_reg.seconds_left       <= '0;
            state_reg.wait_pir_low       <= 1'b0;
            state_reg.pir_qualified      <= 1'b0;
            cfg_reg.manual_timer_minutes <= '0;
            cfg_reg.auto_timer_minutes   <= prlc_pkg::AUTO_W'(prlc_pkg::AUTO_RESET);
            cfg_reg.day_night_enabled    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg <= prlc_pkg::item_t'(s_tdata[$bits(prlc_pkg::item_t)-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    // lockout is only ever set in auto mode and any mode change clears it
    a_lockout_only_auto: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.wait_pir_low |-> (state_reg.mode == prlc_pkg::MODE_AUTO))
        else $error("lockout set outside auto mode");

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mode != prlc_pkg::MODE_KEEP)
        else $error("mode register holds the keep code");

    a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seconds_left <= prlc_pkg::SECONDS_W'(prlc_pkg::SECONDS_MAX))
        else $error("off timer above its maximum");

    // a stalled result must not let the controller state move on
    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(state_reg))
        else $error("state changed while result stalled");
`endif

endmodule

// ===== rtl/prlc_next_state.sv =====
module prlc_next_state (
    input  prlc_pkg::item_t  item,
    input  prlc_pkg::state_t state,
    input  prlc_pkg::cfg_t   cfg,
    output prlc_pkg::state_t state_next
);

    logic [prlc_pkg::SECONDS_W-1:0] manual_secs;
    logic [prlc_pkg::SECONDS_W-1:0] auto_secs;
    logic                           blocked;
    prlc_pkg::state_t               upd;

    assign manual_secs = prlc_pkg::minutes_to_seconds(cfg.manual_timer_minutes);
    assign auto_secs   = prlc_pkg::minutes_to_seconds(
                             prlc_pkg::MANUAL_W'(cfg.auto_timer_minutes));
    assign blocked     = cfg.day_night_enabled && item.is_day;

    // periodic update: lockout filter, timer countdown, mode action
    always_comb
    begin
        upd = state;
        if (state.wait_pir_low)
        begin
            if (!item.pir_level)
            begin
                upd.wait_pir_low = 1'b0;
            end
            upd.pir_qualified = 1'b0;
        end
        else
        begin
            upd.pir_qualified = item.pir_level;
        end

        if ((state.seconds_left != '0) && item.second_tick)
        begin
            if (state.seconds_left == prlc_pkg::SECONDS_W'(1))
            begin
                upd.relay        = 1'b0;
                upd.seconds_left = '0;
            end
            else
            begin
                upd.seconds_left = state.seconds_left - prlc_pkg::SECONDS_W'(1);
            end
        end

        if (state.mode == prlc_pkg::MODE_ALARM)
        begin
            upd.relay = 1'b0;
        end
        else if (state.mode == prlc_pkg::MODE_AUTO)
        begin
            if (!blocked && !upd.wait_pir_low && upd.pir_qualified)
            begin
                upd.relay        = 1'b1;
                upd.seconds_left = auto_secs;
            end
        end
    end

    always_comb
    begin
        state_next = state;
        unique case (item.cmd)
            prlc_pkg::CMD_UPDATE:
            begin
                state_next = upd;
            end
            prlc_pkg::CMD_TOGGLE:
            begin
                state_next.relay        = !state.relay;
                state_next.seconds_left = state.relay ? '0 : manual_secs;
                if (state.mode == prlc_pkg::MODE_AUTO)
                begin
                    state_next.wait_pir_low = 1'b1;
                end
            end
            prlc_pkg::CMD_SET_MODE:
            begin
                if (item.new_mode != prlc_pkg::MODE_KEEP)
                begin
                    state_next.mode = item.new_mode;
                end
                state_next.relay        = 1'b0;
                state_next.seconds_left = '0;
                state_next.wait_pir_low = 1'b0;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ===== verif/tb.sv =====
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [prlc_pkg::CMD_W-1:0]       CMD_UNUSED = 2'd3;
    localparam logic [prlc_pkg::CFG_INDEX_W-1:0] REG_NONE   = 2'd3;

    // result fields from the lowest bit up: relay, motion, seconds, mode, lockout
    typedef struct packed {
        logic                           lockout;
        logic [prlc_pkg::MODE_W-1:0]    mode;
        logic [prlc_pkg::SECONDS_W-1:0] seconds;
        logic                           motion;
        logic                           relay;
    } status_t;

    localparam int unsigned STATUS_W = $bits(status_t);

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [prlc_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [prlc_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                             cfg_wr_en;
    logic [prlc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [prlc_pkg::CFG_DATA_W-1:0]  cfg_data;

    pir_relay_light_controller_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // controller state as predicted
    logic [prlc_pkg::MODE_W-1:0]    st_mode;
    logic                           st_relay;
    logic [prlc_pkg::SECONDS_W-1:0] st_seconds;
    logic                           st_lockout;
    logic                           st_motion;

    logic [prlc_pkg::MANUAL_W-1:0]  cfg_manual;
    logic [prlc_pkg::AUTO_W-1:0]    cfg_auto;
    logic                           cfg_day_block;

    status_t status_queue[$];

    int  cmd_count[4];
    int  expiries;
    int  lockout_releases;
    int  results_checked;
    int  mismatches;
    int  unexpected;
    int  input_stalls;
    int  hold_request;
    bit  no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", status_queue.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [prlc_pkg::SECONDS_W-1:0] to_seconds(input int unsigned minutes);
        return prlc_pkg::SECONDS_W'(minutes * prlc_pkg::SECS_PER_MIN);
    endfunction

    function automatic status_t apply_command(input prlc_pkg::item_t it);
        logic    blocked;
        status_t r;
        case (it.cmd)
            prlc_pkg::CMD_UPDATE:
            begin
                if (st_lockout)
                begin
                    if (!it.pir_level)
                    begin
                        st_lockout = 1'b0;
                        lockout_releases++;
                    end
                    st_motion = 1'b0;
                end
                else
                    st_motion = it.pir_level;
                if (st_seconds != '0 && it.second_tick)
                begin
                    if (st_seconds == prlc_pkg::SECONDS_W'(1))
                    begin
                        st_relay   = 1'b0;
                        st_seconds = '0;
                        expiries++;
                    end
                    else
                        st_seconds = st_seconds - 1'b1;
                end
                if (st_mode == prlc_pkg::MODE_ALARM)
                    st_relay = 1'b0;
                else if (st_mode == prlc_pkg::MODE_AUTO)
                begin
                    blocked = cfg_day_block && it.is_day;
                    // motion re-arms a running timer as well as switching on
                    if (!blocked && !st_lockout && st_motion)
                    begin
                        st_relay   = 1'b1;
                        st_seconds = to_seconds(cfg_auto);
                    end
                end
            end
            prlc_pkg::CMD_TOGGLE:
            begin
                st_relay = ~st_relay;
                st_seconds = st_relay ? to_seconds(cfg_manual) : '0;
                if (st_mode == prlc_pkg::MODE_AUTO)
                    st_lockout = 1'b1;
            end
            prlc_pkg::CMD_SET_MODE:
            begin
                if (it.new_mode != prlc_pkg::MODE_KEEP)
                    st_mode = it.new_mode;
                st_relay   = 1'b0;
                st_seconds = '0;
                st_lockout = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.relay   = st_relay;
        r.motion  = st_motion;
        r.seconds = st_seconds;
        r.mode    = st_mode;
        r.lockout = st_lockout;
        return r;
    endfunction

    function automatic prlc_pkg::item_t make_item(input logic [prlc_pkg::CMD_W-1:0] c,
                                                  input logic pir,
                                                  input logic day, input logic tick,
                                                  input logic [prlc_pkg::MODE_W-1:0] nm);
        prlc_pkg::item_t it;
        it.cmd         = c;
        it.pir_level   = pir;
        it.is_day      = day;
        it.second_tick = tick;
        it.new_mode    = nm;
        return it;
    endfunction

    function automatic prlc_pkg::item_t random_item(input int upd_pct, input int pir_pct);
        logic [prlc_pkg::CMD_W-1:0] c;
        int                         pick;
        if ($urandom_range(0, 99) < upd_pct)
            c = prlc_pkg::CMD_UPDATE;
        else
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                c = prlc_pkg::CMD_TOGGLE;
            else if (pick < 8)
                c = prlc_pkg::CMD_SET_MODE;
            else
                c = CMD_UNUSED;
        end
        return make_item(c, $urandom_range(0, 99) < pir_pct, 1'($urandom_range(0, 1)),
                         $urandom_range(0, 3) != 0,
                         prlc_pkg::MODE_W'($urandom_range(0, 3)));
    endfunction

    task automatic write_reg(input logic [prlc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [prlc_pkg::CFG_DATA_W-1:0] value);
        logic [prlc_pkg::AUTO_W-1:0] v;
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            prlc_pkg::REG_MANUAL_TIMER:
                cfg_manual = (value > prlc_pkg::MANUAL_MAX) ?
                             prlc_pkg::MANUAL_W'(prlc_pkg::MANUAL_MAX) : value;
            prlc_pkg::REG_AUTO_TIMER:
            begin
                v = value[prlc_pkg::AUTO_W-1:0];
                if (v < prlc_pkg::AUTO_MIN)
                    v = prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MIN);
                if (v > prlc_pkg::AUTO_MAX)
                    v = prlc_pkg::AUTO_W'(prlc_pkg::AUTO_MAX);
                cfg_auto = v;
            end
            prlc_pkg::REG_DAY_NIGHT:
                cfg_day_block = value[0];
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input prlc_pkg::item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= prlc_pkg::IN_DATA_W'(it);
        do @(posedge clk); while (!s_tready);
        status_queue.push_back(apply_command(it));
        cmd_count[it.cmd]++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic test_manual_control();
        send_item(make_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1, prlc_pkg::MODE_KEEP));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b1, 1'b1, prlc_pkg::MODE_ALARM));
        // manual timer 0: relay comes on with no timer
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b0, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b1, 1'b0, 1'b1, prlc_pkg::MODE_AUTO));
        wait_idle();
        write_reg(prlc_pkg::REG_MANUAL_TIMER, 8'hff);
        write_reg(REG_NONE, 8'hff);
        write_reg(prlc_pkg::REG_AUTO_TIMER, 8'h3f);
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b1, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b0, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_KEEP));
    endtask

    task automatic test_auto_lockout();
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b1, 1'b0, 1'b1, prlc_pkg::MODE_AUTO));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b1, 1'b1, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        // low sample drops the lockout but still reports no motion
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b0, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        wait_idle();
    endtask

    task automatic test_day_and_alarm();
        write_reg(prlc_pkg::REG_DAY_NIGHT, 8'h01);
        write_reg(prlc_pkg::REG_AUTO_TIMER, 8'h00);
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_AUTO));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b1, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b1, 1'b1, 1'b0, prlc_pkg::MODE_ALARM));
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        wait_idle();
        write_reg(prlc_pkg::REG_MANUAL_TIMER, 8'h00);
        write_reg(prlc_pkg::REG_DAY_NIGHT, 8'h00);
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        wait_idle();
    endtask

    task automatic test_timer_expiry();
        write_reg(prlc_pkg::REG_MANUAL_TIMER, 8'h01);
        write_reg(prlc_pkg::REG_AUTO_TIMER, 8'h00);
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_AUTO));
        send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b1, 1'b0, 1'b1, prlc_pkg::MODE_MANUAL));
        repeat (62)
            send_item(make_item(prlc_pkg::CMD_UPDATE, 1'b0, 1'($urandom_range(0, 1)), 1'b1,
                                prlc_pkg::MODE_W'($urandom_range(0, 3))));
        send_item(make_item(prlc_pkg::CMD_SET_MODE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        send_item(make_item(prlc_pkg::CMD_TOGGLE, 1'b0, 1'b0, 1'b0, prlc_pkg::MODE_MANUAL));
        repeat (62)
            send_item(make_item(prlc_pkg::CMD_UPDATE, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'b1,
                                prlc_pkg::MODE_W'($urandom_range(0, 3))));
        wait_idle();
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_request = 100;
        repeat (24)
            send_item(random_item(70, 50));
        no_gaps = 1'b0;
        // sender stops until every result is back
        wait_idle();
        repeat (12)
            send_item(random_item(70, 50));
        wait_idle();
    endtask

    task automatic test_random_settings();
        logic [prlc_pkg::CFG_DATA_W-1:0] manual_raw [6] =
            '{8'd0, 8'd1, 8'd255, 8'd2, 8'd180, 8'd0};
        logic [prlc_pkg::CFG_DATA_W-1:0] auto_raw   [6] =
            '{8'd0, 8'd1, 8'd63, 8'd2, 8'd60, 8'd0};
        logic [prlc_pkg::CFG_DATA_W-1:0] day_raw    [6] =
            '{8'd0, 8'd1, 8'd0, 8'd255, 8'd1, 8'd0};
        int                              pir_pct    [6] = '{10, 30, 50, 20, 60, 40};
        int                              upd_pct    [6] = '{70, 85, 60, 75, 80, 65};
        for (int p = 0; p < 6; p++)
        begin
            if (p == 5)
            begin
                manual_raw[p] = prlc_pkg::CFG_DATA_W'($urandom_range(0, 255));
                auto_raw[p]   = prlc_pkg::CFG_DATA_W'($urandom_range(0, 255));
                day_raw[p]    = prlc_pkg::CFG_DATA_W'($urandom_range(0, 255));
            end
            write_reg(prlc_pkg::REG_MANUAL_TIMER, manual_raw[p]);
            write_reg(prlc_pkg::REG_AUTO_TIMER, auto_raw[p]);
            write_reg(prlc_pkg::REG_DAY_NIGHT, day_raw[p]);
            for (int i = 0; i < 185; i++)
            begin
                if (i % 30 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                send_item(random_item(upd_pct[p], pir_pct[p]));
            end
            no_gaps = 1'b0;
            wait_idle();
        end
    endtask

    // result receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
            end
            else
                stall = no_gaps ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
            input_stalls++;
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = status_t'(m_tdata[STATUS_W-1:0]);
            if (status_queue.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result transaction: %h", m_tdata);
            end
            else
            begin
                want = status_queue.pop_front();
                results_checked++;
                if (got.relay !== want.relay || got.motion !== want.motion
                    || got.seconds !== want.seconds || got.mode !== want.mode
                    || got.lockout !== want.lockout
                    || m_tdata[prlc_pkg::OUT_DATA_W-1:STATUS_W] !== '0)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display({"result %0d mismatch: exp relay=%0d motion=%0d secs=%0d ",
                                  "mode=%0d lock=%0d got relay=%0d motion=%0d secs=%0d ",
                                  "mode=%0d lock=%0d pad=%h"},
                                 results_checked, want.relay, want.motion, want.seconds,
                                 want.mode, want.lockout, got.relay, got.motion,
                                 got.seconds, got.mode, got.lockout,
                                 m_tdata[prlc_pkg::OUT_DATA_W-1:STATUS_W]);
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_request = 0;
        no_gaps      = 1'b0;
        st_mode      = prlc_pkg::MODE_MANUAL;
        st_relay     = 1'b0;
        st_seconds   = '0;
        st_lockout   = 1'b0;
        st_motion    = 1'b0;
        cfg_manual    = '0;
        cfg_auto      = prlc_pkg::AUTO_W'(prlc_pkg::AUTO_RESET);
        cfg_day_block = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_manual_control();
        test_auto_lockout();
        test_day_and_alarm();
        test_timer_expiry();
        test_backpressure();
        test_random_settings();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_queue.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display({"ran %0d updates, %0d toggles, %0d mode sets, %0d unused commands; ",
                  "%0d results checked"},
                 cmd_count[prlc_pkg::CMD_UPDATE], cmd_count[prlc_pkg::CMD_TOGGLE],
                 cmd_count[prlc_pkg::CMD_SET_MODE], cmd_count[CMD_UNUSED], results_checked);
        $display("%0d timer expiries, %0d lockout releases, %0d input stall cycles, %0d errors",
                 expiries, lockout_releases, input_stalls, mismatches + unexpected);
        if (mismatches == 0 && unexpected == 0 && status_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
